/* design/rso_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rso_pkg
// Shared widths, register codes and the per-cell control bundle for the
// region sum and occupancy block.
// ----------------------------------------------------------------------------
package rso_pkg;

  localparam int PIX_W    = 16;
  localparam int TAG_W    = 32;
  localparam int IDX_W    = 4;
  localparam int COORD_W  = 12;
  localparam int SIZE_W   = 13;
  localparam int SUM_W    = 40;
  localparam int ACT_W    = 5;
  localparam int CFG_IX_W = 2;
  localparam int CFG_D_W  = 13;

  // reachable table entries through the 4-bit entry index
  localparam int NUM_ENTRIES = 16;

  localparam int MAX_ROIS_DEF = 16;
  localparam int MAX_DIM_DEF  = 4096;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [ACT_W-1:0]  ACTIVE_RST = 5'd16;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_ACTIVE = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_LOAD  = 1'b1
  } op_e;

  typedef struct packed {
    logic pix_en;
    logic frame_start;
    logic capture;
    logic shift;
  } cell_ctrl_t;

endpackage

/* design/rso_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rso_if
// Valid/ready channels: pixel and region-load beats in, region results out.
// ----------------------------------------------------------------------------
interface rso_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [rso_pkg::PIX_W-1:0]         pixel_value;
  logic [rso_pkg::TAG_W-1:0]         frame_tag;
  logic [rso_pkg::IDX_W-1:0]         entry_index;
  logic [rso_pkg::COORD_W-1:0]       region_left;
  logic [rso_pkg::COORD_W-1:0]       region_top;
  logic [rso_pkg::SIZE_W-1:0]        region_width;
  logic [rso_pkg::SIZE_W-1:0]        region_height;
  logic [rso_pkg::SUM_W-1:0]         region_threshold;

  modport source (
    output valid, operation, pixel_value, frame_tag, entry_index, region_left,
           region_top, region_width, region_height, region_threshold,
    input  ready
  );
  modport sink (
    input  valid, operation, pixel_value, frame_tag, entry_index, region_left,
           region_top, region_width, region_height, region_threshold,
    output ready
  );
endinterface

interface rso_out_if;
  logic                      valid;
  logic                      ready;
  logic [rso_pkg::IDX_W-1:0] region_number;
  logic [rso_pkg::SUM_W-1:0] region_sum;
  logic                      occupied;
  logic [rso_pkg::TAG_W-1:0] tag_out;
  logic                      last_region;

  modport source (
    output valid, region_number, region_sum, occupied, tag_out, last_region,
    input  ready
  );
  modport sink (
    input  valid, region_number, region_sum, occupied, tag_out, last_region,
    output ready
  );
endinterface

/* design/rso_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rso_cell
// One region entry: rectangle, threshold and running sum. At frame end the
// cell captures its result and then passes results down the chain.
// ----------------------------------------------------------------------------
module rso_cell #(
  parameter int CW = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rso_pkg::cell_ctrl_t             ctrl_i,
  input  logic                            live_i,
  input  logic [CW-1:0]                   col_i,
  input  logic [CW-1:0]                   row_i,
  input  logic [rso_pkg::PIX_W-1:0]       pixel_i,
  input  logic                            wr_en_i,
  input  logic [rso_pkg::COORD_W-1:0]     left_i,
  input  logic [rso_pkg::COORD_W-1:0]     top_i,
  input  logic [rso_pkg::SIZE_W-1:0]      width_i,
  input  logic [rso_pkg::SIZE_W-1:0]      height_i,
  input  logic [rso_pkg::SUM_W-1:0]       thr_i,
  input  logic [rso_pkg::SUM_W-1:0]       nb_sum_i,
  input  logic                            nb_occ_i,
  output logic [rso_pkg::SUM_W-1:0]       res_sum_o,
  output logic                            res_occ_o
);

  localparam int CMPW = ((CW > rso_pkg::SIZE_W) ? CW : rso_pkg::SIZE_W) + 1;

  logic [rso_pkg::COORD_W-1:0] left_q, top_q;
  logic [rso_pkg::SIZE_W-1:0]  width_q, height_q;
  logic [rso_pkg::SUM_W-1:0]   thr_q;
  logic [rso_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [rso_pkg::SUM_W-1:0]   res_sum_q, res_sum_d;
  logic                        res_occ_q, res_occ_d;

  logic [CMPW-1:0]             col_x, row_x, left_x, top_x, right_x, bottom_x;
  logic                        hit;
  logic [rso_pkg::SUM_W-1:0]   base;
  logic [rso_pkg::SUM_W:0]     acc;

  always_comb begin
    col_x    = CMPW'(col_i);
    row_x    = CMPW'(row_i);
    left_x   = CMPW'(left_q);
    top_x    = CMPW'(top_q);
    right_x  = CMPW'(left_q) + CMPW'(width_q);
    bottom_x = CMPW'(top_q) + CMPW'(height_q);
    hit = live_i && (col_x >= left_x) && (col_x < right_x) &&
          (row_x >= top_x) && (row_x < bottom_x);
    base = ctrl_i.frame_start ? '0 : sum_q;
    acc  = {1'b0, base} + (rso_pkg::SUM_W + 1)'(pixel_i);
    if (!ctrl_i.pix_en) begin
      sum_d = sum_q;
    end else if (hit) begin
      sum_d = acc[rso_pkg::SUM_W] ? '1 : acc[rso_pkg::SUM_W-1:0];
    end else begin
      sum_d = base;
    end
    if (ctrl_i.capture) begin
      res_sum_d = sum_q;
      res_occ_d = (sum_q >= thr_q);
    end else if (ctrl_i.shift) begin
      res_sum_d = nb_sum_i;
      res_occ_d = nb_occ_i;
    end else begin
      res_sum_d = res_sum_q;
      res_occ_d = res_occ_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      thr_q    <= '0;
      sum_q    <= '0;
    end else begin
      if (wr_en_i) begin
        left_q   <= left_i;
        top_q    <= top_i;
        width_q  <= width_i;
        height_q <= height_i;
        thr_q    <= thr_i;
      end
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_sum_q <= res_sum_d;
    res_occ_q <= res_occ_d;
  end

  assign res_sum_o = res_sum_q;
  assign res_occ_o = res_occ_q;

endmodule

/* design/rso_raster.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rso_raster
// Configuration registers, raster position, frame tag and the sequencer that
// drives the cell chain and the result readout.
// ----------------------------------------------------------------------------
module rso_raster #(
  parameter int NCELL   = 16,
  parameter int MAX_DIM = 4096,
  parameter int CW      = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rso_pkg::CFG_IX_W-1:0]     cfg_idx_i,
  input  logic [rso_pkg::CFG_D_W-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_op_i,
  input  logic [rso_pkg::TAG_W-1:0]        frame_tag_i,
  output logic                             in_ready_o,
  output logic                             load_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output rso_pkg::cell_ctrl_t              ctrl_o,
  output logic [NCELL-1:0]                 live_o,
  output logic [CW-1:0]                    col_o,
  output logic [CW-1:0]                    row_o,
  output logic [rso_pkg::IDX_W-1:0]        region_number_o,
  output logic [rso_pkg::TAG_W-1:0]        tag_o,
  output logic                             last_o
);

  localparam int DW = ($clog2(MAX_DIM + 1) > rso_pkg::SIZE_W) ?
                      $clog2(MAX_DIM + 1) : rso_pkg::SIZE_W;
  localparam int NW = $clog2(NCELL + 1);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_CAPTURE = 3'b010,
    ST_DRAIN   = 3'b100
  } state_e;

  state_e                       state_q, state_d;
  logic [rso_pkg::SIZE_W-1:0]   width_q, height_q;
  logic [rso_pkg::ACT_W-1:0]    active_q;
  logic [CW-1:0]                col_q, col_d, row_q, row_d;
  logic [rso_pkg::TAG_W-1:0]    tag_q;
  logic [NW-1:0]                n_q, n_d, idx_q, idx_d;

  logic                         pix_acc, frame_start, row_end, frame_end;
  logic [DW-1:0]                w_eff, h_eff, col_inc, row_inc;
  logic [NW-1:0]                n_live, idx_inc;

  function automatic logic [DW-1:0] clamp_dim(input logic [rso_pkg::SIZE_W-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (DW'(v) > DW'(MAX_DIM)) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_DRAIN);
    pix_acc     = in_valid_i && in_ready_o && (in_op_i == rso_pkg::OP_PIXEL);
    load_o      = in_valid_i && in_ready_o && (in_op_i == rso_pkg::OP_LOAD);
    frame_start = (col_q == '0) && (row_q == '0);
    w_eff       = clamp_dim(width_q);
    h_eff       = clamp_dim(height_q);
    col_inc     = DW'(col_q) + DW'(1);
    row_inc     = DW'(row_q) + DW'(1);
    row_end     = (col_inc >= w_eff);
    frame_end   = row_end && (row_inc >= h_eff);
    n_live      = (active_q > rso_pkg::ACT_W'(NCELL)) ? NW'(NCELL) : NW'(active_q);
    idx_inc     = idx_q + NW'(1);

    // only entries below the live count accumulate
    for (int g = 0; g < NCELL; g++) begin
      live_o[g] = (n_live > NW'(g));
    end

    col_d   = col_q;
    row_d   = row_q;
    n_d     = n_q;
    idx_d   = idx_q;
    state_d = state_q;

    if (pix_acc) begin
      if (!row_end) begin
        col_d = CW'(col_inc);
      end else if (!frame_end) begin
        col_d = '0;
        row_d = CW'(row_inc);
      end else begin
        col_d = '0;
        row_d = '0;
        n_d   = n_live;
        if (n_live != '0) begin
          state_d = ST_CAPTURE;
        end
      end
    end

    case (state_q)
      ST_IDLE: begin
      end
      ST_CAPTURE: begin
        idx_d   = '0;
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_ready_i) begin
          idx_d = idx_inc;
          if (idx_inc == n_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    ctrl_o.pix_en      = pix_acc;
    ctrl_o.frame_start = frame_start;
    ctrl_o.capture     = (state_q == ST_CAPTURE);
    ctrl_o.shift       = out_valid_o && out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      width_q  <= rso_pkg::WIDTH_RST;
      height_q <= rso_pkg::HEIGHT_RST;
      active_q <= rso_pkg::ACTIVE_RST;
      col_q    <= '0;
      row_q    <= '0;
      tag_q    <= '0;
      n_q      <= '0;
      idx_q    <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      n_q     <= n_d;
      idx_q   <= idx_d;
      if (pix_acc && frame_start) begin
        tag_q <= frame_tag_i;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rso_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
          rso_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
          rso_pkg::CFG_ACTIVE: active_q <= cfg_data_i[rso_pkg::ACT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign col_o           = col_q;
  assign row_o           = row_q;
  assign tag_o           = tag_q;
  assign region_number_o = rso_pkg::IDX_W'(idx_q);
  assign last_o          = (idx_inc == n_q);

endmodule

/* design/roi_sum_occupancy.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roi_sum_occupancy
// Per-region pixel sums with occupancy flags over a raster pixel stream.
// Throughput: one pixel or region-load beat per cycle outside readout; every
// cell tests each pixel in parallel. A frame's last pixel beat leads to a
// capture state, where each cell registers its result; the n results then
// leave the cell chain one per cycle while the sink is ready; no input is taken.
// Reset: configuration to 640 x 480 with 16 regions, all tables and sums zero.
// ----------------------------------------------------------------------------
module roi_sum_occupancy #(
  parameter int MAX_ROIS = rso_pkg::MAX_ROIS_DEF,
  parameter int MAX_DIM  = rso_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rso_pkg::CFG_IX_W-1:0]  cfg_idx_i,
  input  logic [rso_pkg::CFG_D_W-1:0]   cfg_data_i,
  rso_in_if.sink                        in_i,
  rso_out_if.source                     out_o
);

  localparam int NCELL = (MAX_ROIS < rso_pkg::NUM_ENTRIES) ? MAX_ROIS :
                         rso_pkg::NUM_ENTRIES;
  localparam int CW    = $clog2(MAX_DIM);

  rso_pkg::cell_ctrl_t       ctrl;
  logic [NCELL-1:0]          live;
  logic [CW-1:0]             col, row;
  logic                      load;
  logic [rso_pkg::SUM_W-1:0] chain_sum [NCELL+1];
  logic                      chain_occ [NCELL+1];

  rso_raster #(
    .NCELL   (NCELL),
    .MAX_DIM (MAX_DIM),
    .CW      (CW)
  ) u_raster (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_i.valid),
    .in_op_i         (in_i.operation),
    .frame_tag_i     (in_i.frame_tag),
    .in_ready_o      (in_i.ready),
    .load_o          (load),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .ctrl_o          (ctrl),
    .live_o          (live),
    .col_o           (col),
    .row_o           (row),
    .region_number_o (out_o.region_number),
    .tag_o           (out_o.tag_out),
    .last_o          (out_o.last_region)
  );

  assign chain_sum[NCELL] = '0;
  assign chain_occ[NCELL] = 1'b0;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    rso_cell #(
      .CW (CW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .live_i    (live[g]),
      .col_i     (col),
      .row_i     (row),
      .pixel_i   (in_i.pixel_value),
      .wr_en_i   (load && (in_i.entry_index == rso_pkg::IDX_W'(g))),
      .left_i    (in_i.region_left),
      .top_i     (in_i.region_top),
      .width_i   (in_i.region_width),
      .height_i  (in_i.region_height),
      .thr_i     (in_i.region_threshold),
      .nb_sum_i  (chain_sum[g+1]),
      .nb_occ_i  (chain_occ[g+1]),
      .res_sum_o (chain_sum[g]),
      .res_occ_o (chain_occ[g])
    );
  end

  assign out_o.region_sum = chain_sum[0];
  assign out_o.occupied   = chain_occ[0];

endmodule

/* design/rso_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rso_checker
// Port-level checks on the result readout, bound to the top level.
// ----------------------------------------------------------------------------
module rso_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_ready_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [rso_pkg::IDX_W-1:0] region_number_i,
  input  logic [rso_pkg::SUM_W-1:0] region_sum_i,
  input  logic [rso_pkg::TAG_W-1:0] tag_out_i,
  input  logic                      last_region_i
);

  // no input beat is taken while results are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_i && in_ready_i))
    else $error("input ready during result readout");

  // readout ends right after the last beat
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && last_region_i) |=> !out_valid_i)
    else $error("results continue after last region");

  // results follow in entry order with one frame tag
  a_next_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !last_region_i) |=>
      (out_valid_i &&
       region_number_i == rso_pkg::IDX_W'($past(region_number_i) + 1'b1) &&
       $stable(tag_out_i)))
    else $error("region order or tag broken within a frame");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(region_sum_i) && $stable(region_number_i)))
    else $error("stalled result beat changed");

endmodule

bind roi_sum_occupancy rso_checker u_rso_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .region_number_i (out_o.region_number),
  .region_sum_i    (out_o.region_sum),
  .tag_out_i       (out_o.tag_out),
  .last_region_i   (out_o.last_region)
);
